>>> sv/dfawa_pkg.sv
// Shared types and constants for the DFA word acceptor.
package dfawa_pkg;

    // Fixed field widths of the stream items.
    localparam int STATE_W  = 4;
    localparam int SYMIN_W  = 8;
    localparam int OPCODE_W = 2;
    localparam int STATUS_W = 2;
    localparam int SCOUNT_W = 5;
    localparam int FMASK_W  = 16;
    localparam int ALPHA_W  = 256;
    localparam int CFG_DW   = 64;
    localparam int CFG_AW   = 6;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 8;

    // Item opcodes.
    typedef enum logic [OPCODE_W-1:0] {
        OP_ADD    = 2'd0,
        OP_SYMBOL = 2'd1,
        OP_END    = 2'd2
    } opcode_t;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_BAD_PARAM = 2'd1,
        ST_DUPLICATE = 2'd2,
        ST_CONFLICT  = 2'd3
    } status_t;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_STATE_COUNT   = 3'd0;
    localparam logic [2:0] REG_INITIAL_STATE = 3'd1;
    localparam logic [2:0] REG_FINAL_MASK    = 3'd2;
    localparam logic [2:0] REG_ALPHA_0       = 3'd3;
    localparam logic [2:0] REG_ALPHA_1       = 3'd4;
    localparam logic [2:0] REG_ALPHA_2       = 3'd5;
    localparam logic [2:0] REG_ALPHA_3       = 3'd6;

    localparam logic [SCOUNT_W-1:0] STATE_COUNT_RST = 5'd16;

    // One transition table entry.
    typedef struct packed {
        logic               valid;
        logic [STATE_W-1:0] target;
    } entry_t;

    // Configuration seen by the datapath.
    typedef struct packed {
        logic [SCOUNT_W-1:0] state_count;
        logic [STATE_W-1:0]  initial_state;
        logic [FMASK_W-1:0]  final_mask;
        logic [ALPHA_W-1:0]  alphabet;
    } cfg_t;

endpackage

>>> sv/dfawa_cfg_regs.sv
// APB configuration registers of the DFA word acceptor.
module dfawa_cfg_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dfawa_pkg::CFG_AW-1:0]  paddr,
    input  logic [dfawa_pkg::CFG_DW-1:0]  pwdata,
    output logic [dfawa_pkg::CFG_DW-1:0]  prdata,
    output logic                          pready,
    output dfawa_pkg::cfg_t               cfg
);
    import dfawa_pkg::*;

    logic [SCOUNT_W-1:0] state_count_reg;
    logic [STATE_W-1:0]  initial_state_reg;
    logic [FMASK_W-1:0]  final_mask_reg;
    logic [CFG_DW-1:0]   alpha0_reg, alpha1_reg, alpha2_reg, alpha3_reg;
    logic [2:0]          reg_index;
    logic                wr_fire;

    assign pready    = 1'b1;
    assign reg_index = paddr[CFG_AW-1:3];
    assign wr_fire   = psel && penable && pwrite && pready;

    // Register writes complete in the access phase.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_count_reg   <= STATE_COUNT_RST;
            initial_state_reg <= '0;
            final_mask_reg    <= '0;
            alpha0_reg        <= '0;
            alpha1_reg        <= '0;
            alpha2_reg        <= '0;
            alpha3_reg        <= '0;
        end else if (wr_fire) begin
            unique case (reg_index)
                REG_STATE_COUNT:   state_count_reg   <= pwdata[SCOUNT_W-1:0];
                REG_INITIAL_STATE: initial_state_reg <= pwdata[STATE_W-1:0];
                REG_FINAL_MASK:    final_mask_reg    <= pwdata[FMASK_W-1:0];
                REG_ALPHA_0:       alpha0_reg        <= pwdata;
                REG_ALPHA_1:       alpha1_reg        <= pwdata;
                REG_ALPHA_2:       alpha2_reg        <= pwdata;
                REG_ALPHA_3:       alpha3_reg        <= pwdata;
                default: ;
            endcase
        end
    end

    // Read data multiplexer.
    always_comb begin
        unique case (reg_index)
            REG_STATE_COUNT:   prdata = CFG_DW'(state_count_reg);
            REG_INITIAL_STATE: prdata = CFG_DW'(initial_state_reg);
            REG_FINAL_MASK:    prdata = CFG_DW'(final_mask_reg);
            REG_ALPHA_0:       prdata = alpha0_reg;
            REG_ALPHA_1:       prdata = alpha1_reg;
            REG_ALPHA_2:       prdata = alpha2_reg;
            REG_ALPHA_3:       prdata = alpha3_reg;
            default:           prdata = '0;
        endcase
    end

    assign cfg.state_count   = state_count_reg;
    assign cfg.initial_state = initial_state_reg;
    assign cfg.final_mask    = final_mask_reg;
    assign cfg.alphabet      = {alpha3_reg, alpha2_reg, alpha1_reg, alpha0_reg};

endmodule

>>> sv/dfawa_table_ram.sv
// Transition table memory with a clearing sweep after reset.
module dfawa_table_ram #(
    parameter int ADDR_W = 12
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      rd_en,
    input  logic [ADDR_W-1:0]         rd_addr,
    output dfawa_pkg::entry_t         rd_data,
    input  logic                      wr_en,
    input  logic [ADDR_W-1:0]         wr_addr,
    input  dfawa_pkg::entry_t         wr_data,
    output logic                      clear_busy
);
    import dfawa_pkg::*;

    localparam int DEPTH = 2 ** ADDR_W;

    entry_t             mem [DEPTH];
    entry_t             rd_data_reg;
    logic [ADDR_W-1:0]  clr_addr_reg;
    logic               clr_busy_reg;

    // Sweep counter: one entry cleared per cycle after reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clr_busy_reg) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == '1) begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    // Single write port, shared by the sweep and the datapath.
    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            mem[clr_addr_reg] <= '0;
        end else if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port; data holds while no read is issued.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data    = rd_data_reg;
    assign clear_busy = clr_busy_reg;

endmodule

>>> sv/dfa_word_acceptor_core.sv
// Top level of the DFA word acceptor: stream datapath around the transition table.
// The block takes one item per clock cycle unless the table clear or a stalled
// output holds it off; each item's single result passes through the lookup stage
// and then the output register. Every item reads the transition table once, in the
// cycle it is accepted; for a word symbol the address is formed from the state
// just produced by the previous item, so the table read port sets the pace.
// Add-transition items write the entry back as they leave the lookup stage, and a
// following item that reads the same entry gets the new value forwarded. After
// reset the table, 2**(ROW_W + SYMBOL_BITS) entries (4096 at the defaults, ROW_W =
// the ceiling of log2 of the smaller of MAX_STATES and 16), is cleared one entry per
// cycle; no input transfer is taken during that sweep, while register writes are.
module dfa_word_acceptor_core #(
    parameter int MAX_STATES  = 16,
    parameter int SYMBOL_BITS = 8
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // Configuration port.
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [dfawa_pkg::CFG_AW-1:0]     paddr,
    input  logic [dfawa_pkg::CFG_DW-1:0]     pwdata,
    output logic [dfawa_pkg::CFG_DW-1:0]     prdata,
    output logic                             pready,
    // Input items.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // opcode[1:0]
    input  logic [dfawa_pkg::OPCODE_W-1:0]   s_tuser,
    // from_state[3:0], symbol[11:4], to_state[15:12]
    input  logic [dfawa_pkg::S_TDATA_W-1:0]  s_tdata,
    // Result items.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // status[1:0], accepted[2], present_state[6:3], word_dead[7]
    output logic [dfawa_pkg::M_TDATA_W-1:0]  m_tdata
);
    import dfawa_pkg::*;

    localparam int ROWS   = (MAX_STATES < 16) ? MAX_STATES : 16;
    localparam int ROW_W  = $clog2(ROWS);
    localparam int ADDR_W = ROW_W + SYMBOL_BITS;

    cfg_t cfg;

    // Table port signals.
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    entry_t            rd_data;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    entry_t            wr_data;
    logic              clear_busy;

    // Input field decode.
    logic [OPCODE_W-1:0]    in_op;
    logic [STATE_W-1:0]     in_from;
    logic [SYMBOL_BITS-1:0] in_sym;
    logic [STATE_W-1:0]     in_to;

    // Lookup stage.
    logic                   s1_valid_reg;
    logic [OPCODE_W-1:0]    s1_op_reg;
    logic [STATE_W-1:0]     s1_from_reg;
    logic [SYMBOL_BITS-1:0] s1_sym_reg;
    logic [STATE_W-1:0]     s1_to_reg;
    logic [ADDR_W-1:0]      s1_addr_reg;
    logic                   s1_fwd_reg;
    entry_t                 s1_fwd_data_reg;

    // Architectural word state.
    logic [STATE_W-1:0]     cur_state_reg, cur_state_next;
    logic                   dead_reg, dead_next;

    // Output register.
    logic                   m_valid_reg;
    logic [M_TDATA_W-1:0]   m_data_reg;

    logic                   accept, commit;
    logic [STATE_W-1:0]     cur_eff;
    entry_t                 s1_entry;
    status_t                s1_status;
    logic                   s1_accepted;
    logic                   from_ok, to_ok, sym_ok, row_ok;

    dfawa_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dfawa_table_ram #(
        .ADDR_W (ADDR_W)
    ) u_table (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .clear_busy (clear_busy)
    );

    assign in_op   = s_tuser;
    assign in_from = s_tdata[3:0];
    assign in_sym  = s_tdata[4 +: SYMBOL_BITS];
    assign in_to   = s_tdata[15:12];

    // Handshake: the lookup stage drains into the output register.
    assign commit   = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !clear_busy && (!s1_valid_reg || commit);
    assign accept   = s_tvalid && s_tready;

    // State the accepted item starts from: the result of the item ahead of it.
    assign cur_eff = s1_valid_reg ? cur_state_next : cur_state_reg;

    // Table read address, issued in the transfer cycle.
    always_comb begin
        rd_en = accept;
        if (in_op == OP_ADD) begin
            rd_addr = {in_from[ROW_W-1:0], in_sym};
        end else begin
            rd_addr = {cur_eff[ROW_W-1:0], in_sym};
        end
    end

    // Lookup stage registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s1_fwd_reg   <= 1'b0;
        end else if (accept) begin
            s1_valid_reg <= 1'b1;
            s1_fwd_reg   <= wr_en && (wr_addr == rd_addr);
        end else if (commit) begin
            s1_valid_reg <= 1'b0;
            s1_fwd_reg   <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_op_reg       <= in_op;
            s1_from_reg     <= in_from;
            s1_sym_reg      <= in_sym;
            s1_to_reg       <= in_to;
            s1_addr_reg     <= rd_addr;
            s1_fwd_data_reg <= wr_data;
        end
    end

    // Entry as it stands, including a write made at the read edge.
    assign s1_entry = s1_fwd_reg ? s1_fwd_data_reg : rd_data;

    // Range and alphabet checks of an added transition, and the row check of a symbol.
    assign from_ok = ({1'b0, s1_from_reg} < cfg.state_count) && (int'(s1_from_reg) < ROWS);
    assign to_ok   = ({1'b0, s1_to_reg} < cfg.state_count) && (int'(s1_to_reg) < ROWS);
    assign sym_ok  = cfg.alphabet[8'(s1_sym_reg)];
    assign row_ok  = int'(cur_state_reg) < ROWS;

    // Item execution in the lookup stage.
    always_comb begin
        cur_state_next = cur_state_reg;
        dead_next      = dead_reg;
        s1_status      = ST_OK;
        s1_accepted    = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = s1_addr_reg;
        wr_data.valid  = 1'b1;
        wr_data.target = s1_to_reg;
        unique case (s1_op_reg)
            OP_ADD: begin
                if (!from_ok || !to_ok || !sym_ok) begin
                    s1_status = ST_BAD_PARAM;
                end else if (s1_entry.valid) begin
                    s1_status = (s1_entry.target == s1_to_reg) ? ST_DUPLICATE : ST_CONFLICT;
                end else begin
                    wr_en = commit;
                end
            end
            OP_SYMBOL: begin
                if (!dead_reg) begin
                    if (row_ok && s1_entry.valid) begin
                        cur_state_next = s1_entry.target;
                    end else begin
                        dead_next = 1'b1;
                    end
                end
            end
            OP_END: begin
                s1_accepted    = !dead_reg && cfg.final_mask[cur_state_reg];
                cur_state_next = cfg.initial_state;
                dead_next      = 1'b0;
            end
            default: begin
                s1_status = ST_BAD_PARAM;
            end
        endcase
    end

    // Word state commits as the item leaves the lookup stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_state_reg <= '0;
            dead_reg      <= 1'b0;
        end else if (commit) begin
            cur_state_reg <= cur_state_next;
            dead_reg      <= dead_next;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (commit) begin
            m_data_reg <= {dead_next, cur_state_next, s1_accepted, s1_status};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // No item enters while the table is being cleared.
    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clear_busy |-> !accept)
        else $error("item accepted during table clear");

    // An end of word restarts the word at the initial state, alive.
    a_end_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (commit && s1_op_reg == OP_END) |=>
            (cur_state_reg == $past(cfg.initial_state) && !dead_reg))
        else $error("end of word did not restart the word");

    // A stalled lookup stage keeps its item and its forwarded entry.
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !commit) |=>
            (s1_valid_reg && $stable(s1_addr_reg) && $stable(s1_fwd_reg)))
        else $error("lookup stage changed while stalled");

    // A dead word keeps its state on symbols.
    a_dead_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (commit && s1_op_reg == OP_SYMBOL && dead_reg) |=>
            (dead_reg && $stable(cur_state_reg)))
        else $error("dead word changed state");

endmodule

>>> sim/tb_dfa_word_acceptor_core.sv
// Self-checking testbench for the DFA word acceptor core: stream stimulus, APB setup, predictor.
module tb_dfa_word_acceptor_core;
    import dfawa_pkg::*;

    // Opcode value that the block must answer as a bad parameter.
    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
    localparam int unsigned RECV_HOLD_CYCLES = 400;
    localparam int unsigned ROUNDS = 14;

    // One input item as it appears on {s_tdata, s_tuser}.
    typedef struct packed {
        logic [STATE_W-1:0]  to_state;
        logic [SYMIN_W-1:0]  symbol;
        logic [STATE_W-1:0]  from_state;
        logic [OPCODE_W-1:0] opcode;
    } dfa_item_t;

    // One result item, laid out as on m_tdata.
    typedef struct packed {
        logic               word_dead;
        logic [STATE_W-1:0] present_state;
        logic               accepted;
        status_t            status;
    } match_result_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [CFG_AW-1:0]    paddr = '0;
    logic [CFG_DW-1:0]    pwdata = '0;
    logic [CFG_DW-1:0]    prdata;
    logic                 pready;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [OPCODE_W-1:0]  s_tuser = '0;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    // Shadow of the configuration registers.
    logic [SCOUNT_W-1:0] cfg_states = STATE_COUNT_RST;
    logic [STATE_W-1:0]  cfg_init = '0;
    logic [FMASK_W-1:0]  cfg_final = '0;
    logic [ALPHA_W-1:0]  cfg_alpha = '0;

    // Shadow of the automaton state.
    entry_t             arc_table [4096];
    logic [STATE_W-1:0] cur_state = '0;
    logic               word_dead = 1'b0;

    dfa_item_t     pending_items[$];
    match_result_t predicted_results[$];
    int unsigned   error_count = 0;
    int unsigned   send_gap_pct = 7;
    int unsigned   recv_gap_pct = 73;
    int unsigned   hold_requests = 0;
    int unsigned   hold_seen = 0;
    int unsigned   hold_left = 0;

    dfa_word_acceptor_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #1 aclk = ~aclk;

    // Apply one item to the shadow automaton and return the result it must produce.
    function automatic match_result_t advance_automaton(input dfa_item_t item);
        match_result_t res;
        logic [SCOUNT_W-1:0] n_used;
        logic [11:0] slot;
        res = '0;
        res.status = ST_OK;
        n_used = (cfg_states > 5'd16) ? 5'd16 : cfg_states;
        case (item.opcode)
            OP_ADD: begin
                slot = {item.from_state, item.symbol};
                if (item.from_state >= n_used || item.to_state >= n_used ||
                    !cfg_alpha[item.symbol]) begin
                    res.status = ST_BAD_PARAM;
                end else if (arc_table[slot].valid) begin
                    res.status = (arc_table[slot].target == item.to_state) ?
                                 ST_DUPLICATE : ST_CONFLICT;
                end else begin
                    arc_table[slot].valid = 1'b1;
                    arc_table[slot].target = item.to_state;
                end
            end
            OP_SYMBOL: begin
                slot = {cur_state, item.symbol};
                if (!word_dead) begin
                    if (arc_table[slot].valid) cur_state = arc_table[slot].target;
                    else word_dead = 1'b1;
                end
            end
            OP_END: begin
                res.accepted = !word_dead && cfg_final[cur_state];
                cur_state = cfg_init;
                word_dead = 1'b0;
            end
            default: begin
                res.status = ST_BAD_PARAM;
            end
        endcase
        res.present_state = cur_state;
        res.word_dead = word_dead;
        return res;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    task automatic push_item(input logic [OPCODE_W-1:0] op, input logic [STATE_W-1:0] from_s,
                             input logic [SYMIN_W-1:0] sym, input logic [STATE_W-1:0] to_s);
        pending_items.push_back('{to_state: to_s, symbol: sym,
                                  from_state: from_s, opcode: op});
    endtask

    // Setup and access phase of one register write; the shadow follows at the write edge.
    task automatic write_reg(input logic [2:0] idx, input logic [CFG_DW-1:0] value);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_STATE_COUNT:   cfg_states = value[SCOUNT_W-1:0];
            REG_INITIAL_STATE: cfg_init = value[STATE_W-1:0];
            REG_FINAL_MASK:    cfg_final = value[FMASK_W-1:0];
            REG_ALPHA_0:       cfg_alpha[0 +: 64] = value;
            REG_ALPHA_1:       cfg_alpha[64 +: 64] = value;
            REG_ALPHA_2:       cfg_alpha[128 +: 64] = value;
            REG_ALPHA_3:       cfg_alpha[192 +: 64] = value;
            default: ;
        endcase
    endtask

    task automatic write_alphabet(input logic [ALPHA_W-1:0] alpha);
        write_reg(REG_ALPHA_0, alpha[0 +: 64]);
        write_reg(REG_ALPHA_1, alpha[64 +: 64]);
        write_reg(REG_ALPHA_2, alpha[128 +: 64]);
        write_reg(REG_ALPHA_3, alpha[192 +: 64]);
    endtask

    // Hold the sender until every item went in and every result came out.
    task automatic wait_drained();
        do @(posedge aclk); while (pending_items.size() != 0 || predicted_results.size() != 0);
    endtask

    // Input driver: a stalled transfer stays in place, otherwise offer the next item at random.
    always @(posedge aclk) begin : item_driver
        logic offer;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predicted_results.push_back(advance_automaton(dfa_item_t'({s_tdata, s_tuser})));
                void'(pending_items.pop_front());
            end
            if (s_tvalid && !s_tready) offer = 1'b1;
            else offer = pending_items.size() != 0 && $urandom_range(99) >= send_gap_pct;
            s_tvalid <= offer;
            if (offer) {s_tdata, s_tuser} <= pending_items[0];
        end
    end

    // Result monitor: compare each transfer with the oldest prediction, then pick tready.
    always @(posedge aclk) begin : result_monitor
        match_result_t got;
        match_result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = match_result_t'(m_tdata);
                if (predicted_results.size() == 0) begin
                    $display("%0t: result with nothing expected, expected none, got %h",
                             $time, m_tdata);
                    error_count++;
                end else begin
                    want = predicted_results.pop_front();
                    check_field("status", want.status, got.status);
                    check_field("accepted", want.accepted, got.accepted);
                    check_field("present_state", want.present_state, got.present_state);
                    check_field("word_dead", want.word_dead, got.word_dead);
                end
            end
            // A requested hold-off keeps the result side stalled for a long stretch.
            if (hold_seen != hold_requests) begin
                hold_seen <= hold_requests;
                hold_left <= RECV_HOLD_CYCLES;
                m_tready <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= $urandom_range(99) >= recv_gap_pct;
            end
        end
    end

    // Stimulus sequence: directed items, then rounds of table building and word scans.
    initial begin : stimulus
        int r;
        int k;
        int w;
        int len;
        int pool_n;
        logic [SCOUNT_W-1:0] sc;
        logic [SCOUNT_W-1:0] n_used;
        logic [STATE_W-1:0]  from_s;
        logic [STATE_W-1:0]  to_s;
        logic [STATE_W-1:0]  walk;
        logic [SYMIN_W-1:0]  sym;
        logic [SYMIN_W-1:0]  pool [8];
        logic [SYMIN_W-1:0]  cands[$];
        logic [ALPHA_W-1:0]  alpha;
        logic [FMASK_W-1:0]  fmask;
        logic                alive;
        dfa_item_t           prev_adds[$];

        foreach (arc_table[i]) arc_table[i] = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset configuration: empty alphabet and an empty table.
        push_item(OP_ADD, 4'd0, 8'h41, 4'd1);
        push_item(OP_SYMBOL, 4'd0, 8'h41, 4'd0);
        push_item(OP_SYMBOL, 4'd0, 8'h42, 4'd0);
        push_item(OP_END, 4'd0, 8'h00, 4'd0);
        wait_drained();

        // Oversized state count, top initial state, all states final, full alphabet.
        write_reg(REG_STATE_COUNT, 64'd31);
        write_reg(REG_INITIAL_STATE, 64'd15);
        write_reg(REG_FINAL_MASK, 64'hFFFF);
        write_alphabet({ALPHA_W{1'b1}});
        push_item(OP_ADD, 4'd15, 8'hFF, 4'd0);
        push_item(OP_ADD, 4'd15, 8'hFF, 4'd0);
        push_item(OP_ADD, 4'd15, 8'hFF, 4'd15);
        push_item(OP_ADD, 4'd0, 8'h00, 4'd15);
        push_item(OP_ADD, 4'd0, 8'hFF, 4'd15);
        push_item(OP_ADD, 4'd15, 8'h00, 4'd15);
        push_item(OP_UNUSED, 4'd15, 8'hFF, 4'd15);
        // The new initial state only applies once the current word ends.
        push_item(OP_SYMBOL, 4'd0, 8'h00, 4'd0);
        push_item(OP_SYMBOL, 4'd0, 8'hFF, 4'd0);
        push_item(OP_END, 4'd0, 8'h00, 4'd0);
        push_item(OP_SYMBOL, 4'd0, 8'h00, 4'd0);
        push_item(OP_SYMBOL, 4'd0, 8'h7E, 4'd0);
        push_item(OP_END, 4'd0, 8'h00, 4'd0);
        wait_drained();

        // A state count of zero rejects every add.
        write_reg(REG_STATE_COUNT, 64'd0);
        push_item(OP_ADD, 4'd0, 8'h00, 4'd0);
        wait_drained();

        // A single state and no accepting states.
        write_reg(REG_STATE_COUNT, 64'd1);
        write_reg(REG_FINAL_MASK, 64'h0);
        push_item(OP_ADD, 4'd0, 8'h80, 4'd0);
        push_item(OP_ADD, 4'd1, 8'h80, 4'd0);
        push_item(OP_ADD, 4'd0, 8'h80, 4'd1);
        push_item(OP_SYMBOL, 4'd0, 8'h80, 4'd0);
        push_item(OP_END, 4'd0, 8'h00, 4'd0);
        wait_drained();

        for (r = 0; r < ROUNDS; r++) begin
            if (r < 5) begin
                send_gap_pct = 7;
                recv_gap_pct = 73;
            end else if (r < 10) begin
                send_gap_pct = 73;
                recv_gap_pct = 7;
            end else begin
                send_gap_pct = 0;
                recv_gap_pct = 0;
            end

            // New configuration for this round, written while the block is idle.
            case (r % 5)
                0: sc = 5'd16;
                1: sc = 5'($urandom_range(2, 8));
                2: sc = 5'($urandom_range(1, 16));
                3: sc = 5'($urandom_range(17, 31));
                default: sc = 5'd1;
            endcase
            n_used = (sc > 5'd16) ? 5'd16 : sc;
            pool_n = $urandom_range(3, 8);
            alpha = '0;
            for (k = 0; k < pool_n; k++) begin
                pool[k] = 8'($urandom_range(0, 255));
                alpha[pool[k]] = 1'b1;
            end
            if (r % 3 == 0) begin
                for (k = 0; k < 8; k++) alpha[32*k +: 32] = alpha[32*k +: 32] | $urandom;
            end
            if (r == 7) alpha = {ALPHA_W{1'b1}};
            if (r == 11) alpha = '0;
            fmask = 16'($urandom);
            if (r % 7 == 0) fmask = 16'hFFFF;
            if (r % 7 == 3) fmask = 16'h0000;
            write_reg(REG_STATE_COUNT, 64'(sc));
            write_reg(REG_INITIAL_STATE,
                      (r % 6 == 5) ? 64'd15 : 64'($urandom_range(0, n_used - 1)));
            write_reg(REG_FINAL_MASK, 64'(fmask));
            write_alphabet(alpha);

            // Table building with duplicates, conflicts and out-of-range arcs mixed in.
            prev_adds.delete();
            for (k = 0; k < 18; k++) begin
                if (prev_adds.size() != 0 && $urandom_range(99) < 12) begin
                    pending_items.push_back(prev_adds[$urandom_range(0, prev_adds.size() - 1)]);
                end else begin
                    from_s = 4'($urandom_range(0, n_used - 1));
                    to_s = 4'($urandom_range(0, n_used - 1));
                    sym = pool[$urandom_range(0, pool_n - 1)];
                    case ($urandom_range(0, 19))
                        0: from_s = 4'($urandom_range(0, 15));
                        1: to_s = 4'($urandom_range(0, 15));
                        2: sym = 8'($urandom_range(0, 255));
                        default: ;
                    endcase
                    push_item(OP_ADD, from_s, sym, to_s);
                    prev_adds.push_back(pending_items[$]);
                end
            end
            // The sender pauses here until the table stands as predicted.
            wait_drained();

            // Once the result side holds off for long while words keep streaming in.
            if (r == 12) hold_requests <= hold_requests + 1;

            // Word scans that mostly follow existing arcs.
            push_item(OP_END, 4'($urandom), 8'($urandom), 4'($urandom));
            for (w = 0; w < 7; w++) begin
                len = $urandom_range(0, 8);
                walk = cfg_init;
                alive = 1'b1;
                for (k = 0; k < len; k++) begin
                    cands.delete();
                    for (int p = 0; p < pool_n; p++) begin
                        if (arc_table[{walk, pool[p]}].valid) cands.push_back(pool[p]);
                    end
                    if (alive && cands.size() != 0 && $urandom_range(99) < 88)
                        sym = cands[$urandom_range(0, cands.size() - 1)];
                    else if ($urandom_range(1) == 0)
                        sym = pool[$urandom_range(0, pool_n - 1)];
                    else
                        sym = 8'($urandom_range(0, 255));
                    if (arc_table[{walk, sym}].valid) walk = arc_table[{walk, sym}].target;
                    else alive = 1'b0;
                    push_item(OP_SYMBOL, 4'($urandom), sym, 4'($urandom));
                    if ($urandom_range(99) < 3)
                        push_item(OP_UNUSED, 4'($urandom), 8'($urandom), 4'($urandom));
                end
                push_item(OP_END, 4'($urandom), 8'($urandom), 4'($urandom));
            end
            wait_drained();
        end

        repeat (10) @(posedge aclk);
        if (error_count == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end

    // Run limit, far beyond the slowest correct run.
    initial begin : watchdog
        #1000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> files.f
sv/dfawa_pkg.sv
sv/dfawa_cfg_regs.sv
sv/dfawa_table_ram.sv
sv/dfa_word_acceptor_core.sv
sim/tb_dfa_word_acceptor_core.sv
